FILE: src/assert_macros.svh
// assertion macros shared by the translation buffer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: src/stlb_pkg.sv
// types and constants of the set-associative translation buffer
`default_nettype none

package stlb_pkg;

	localparam int PID_W    = 16;
	localparam int PAGE_W   = 20;
	localparam int FRAME_W  = 8;
	localparam int STATUS_W = 2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic               valid;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} way_t;

	typedef struct packed {
		logic               op;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} req_t;

	typedef struct packed {
		logic                wr;
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
	} res_t;

endpackage

`default_nettype wire

FILE: src/stlb_if.sv
// request and response channel interfaces of the translation buffer
`default_nettype none

interface stlb_req_if;
	import stlb_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [PID_W-1:0]   process_id;
	logic [PAGE_W-1:0]  page_number;
	logic [FRAME_W-1:0] frame_in;

	modport source (
		output valid, operation, process_id, page_number, frame_in,
		input  ready
	);

	modport sink (
		input  valid, operation, process_id, page_number, frame_in,
		output ready
	);
endinterface

interface stlb_rsp_if;
	import stlb_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0]  frame_out;

	modport source (
		output valid, status, frame_out,
		input  ready
	);

	modport sink (
		input  valid, status, frame_out,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/stlb_ram.sv
// generic single-write, single-read memory with registered read data
`default_nettype none

module stlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/stlb_index.sv
// input stage: holds the request and reduces the page number to a set index
`default_nettype none
`include "assert_macros.svh"

module stlb_index #(
	parameter int SETS = 16,
	parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  stlb_pkg::req_t     req_in,
	input  logic               advance,
	output logic               valid_s0,
	output stlb_pkg::req_t     req_s0,
	output logic [SET_W-1:0]   set_s0
);
	import stlb_pkg::*;

	localparam int LOG_SETS = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int SHIFT    = PAGE_W + LOG_SETS;
	localparam int RECIP_W  = PAGE_W + 2;
	localparam int PROD_W   = PAGE_W + RECIP_W;
	localparam int PX_W     = SHIFT + PAGE_W;
	localparam int SETS_W   = $clog2(SETS + 1);
	localparam int QS_W     = PAGE_W + SETS_W;
	localparam int REM_W    = SET_W + 1;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

	logic [PROD_W-1:0] prod_n;
	logic [PROD_W-1:0] prod_s0;
	logic [PX_W-1:0]   prod_x;
	logic [PAGE_W-1:0] quot;
	logic [QS_W-1:0]   qs;
	logic [REM_W-1:0]  rem_raw;
	logic [REM_W-1:0]  rem;

	// page times reciprocal of the set count
	assign prod_n = {{RECIP_W{1'b0}}, req_in.page} * {{PAGE_W{1'b0}}, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (load) begin
			valid_s0 <= 1'b1;
		end else if (advance) begin
			valid_s0 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s0  <= req_in;
			prod_s0 <= prod_n;
		end
	end

	always_comb begin
		prod_x  = PX_W'(prod_s0);
		quot    = prod_x[SHIFT +: PAGE_W];
		qs      = QS_W'(quot) * QS_W'(SETS);
		rem_raw = REM_W'(req_s0.page) - REM_W'(qs);
		if (rem_raw >= REM_W'(SETS)) begin
			rem = rem_raw - REM_W'(SETS);
		end else begin
			rem = rem_raw;
		end
		set_s0 = rem[SET_W-1:0];
	end

	`ASSERT_CLK(a_set_in_range, valid_s0 |-> (SETS_W'(set_s0) < SETS_W'(SETS)), "set out of range")

endmodule

`default_nettype wire

FILE: src/stlb_match.sv
// way compare of one set row and the updated row for a write
`default_nettype none

module stlb_match #(
	parameter int WAYS = 4
) (
	input  stlb_pkg::req_t              req,
	input  stlb_pkg::way_t [WAYS-1:0]   row,
	output stlb_pkg::way_t [WAYS-1:0]   row_new,
	output stlb_pkg::res_t              res
);
	import stlb_pkg::*;

	localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic              hit;
	logic [WAY_IW-1:0] hit_idx;
	logic              free;
	logic [WAY_IW-1:0] free_idx;

	// downward scan so the lowest way wins
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].pid == req.pid && row[w].page == req.page) begin
				hit     = 1'b1;
				hit_idx = WAY_IW'(w);
			end
			if (!row[w].valid) begin
				free     = 1'b1;
				free_idx = WAY_IW'(w);
			end
		end
	end

	always_comb begin
		row_new    = row;
		res.wr     = 1'b0;
		res.status = ST_OK;
		res.frame  = '0;
		unique case (req.op)
			OP_LOOKUP: begin
				if (hit) begin
					res.frame = row[hit_idx].frame;
				end else begin
					res.status = ST_MISS;
				end
			end
			OP_WRITE: begin
				if (hit) begin
					row_new[hit_idx].frame = req.frame;
					res.wr                 = 1'b1;
				end else if (free) begin
					row_new[free_idx].valid = 1'b1;
					row_new[free_idx].pid   = req.pid;
					row_new[free_idx].page  = req.page;
					row_new[free_idx].frame = req.frame;
					res.wr                  = 1'b1;
				end else begin
					res.status = ST_FULL;
				end
			end
			default: begin
				res.status = ST_MISS;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/set_associative_tlb.sv
// Set-associative translation buffer tagged by process id and page number.
// One request transfer per cycle unless the clearing pass or a stalled
// response holds it back. The transfer loads the set index stage, then
// memory read, then compare and write-back load the response into the output
// register; a stalled response holds the pipeline without losing work.
// Each memory row holds all ways of one set; a write to the same set by the
// request just ahead is forwarded from the row last written. After reset a
// clearing pass writes every row invalid, one row per cycle, and no request
// is taken until it ends. Lookups return the frame on a hit and report a
// miss otherwise; writes update a matching entry, fill the lowest free way,
// or report the set full and change nothing.
`default_nettype none
`include "assert_macros.svh"

module set_associative_tlb #(
	parameter int SETS = 16,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	stlb_req_if.sink    req,
	stlb_rsp_if.source  rsp
);
	import stlb_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int ROW_W = WAYS * $bits(way_t);

	logic                clr_busy_q;
	logic [SET_W-1:0]    clr_idx_q;

	req_t                req_n;
	logic                accept;
	logic                s0_v;
	req_t                req_s0;
	logic [SET_W-1:0]    set_s0;
	logic                s0_adv;

	logic                s1_v_q;
	req_t                req_s1;
	logic [SET_W-1:0]    set_s1;
	logic                fwd_s1;
	way_t [WAYS-1:0]     fwd_row_q;
	way_t [WAYS-1:0]     rd_row;
	way_t [WAYS-1:0]     row_s1;
	way_t [WAYS-1:0]     row_new;
	res_t                res;
	logic                s1_adv;
	logic                s1_free;

	logic [ROW_W-1:0]    rdata;
	logic [ROW_W-1:0]    wdata;
	logic [SET_W-1:0]    waddr;
	logic                we;

	logic                out_v_q;
	logic [STATUS_W-1:0] status_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                out_free;

	assign req_n = {req.operation, req.process_id, req.page_number, req.frame_in};

	// handshake chain
	assign out_free  = !out_v_q || rsp.ready;
	assign s1_adv    = s1_v_q && out_free;
	assign s1_free   = !s1_v_q || s1_adv;
	assign s0_adv    = s0_v && s1_free;
	assign req.ready = !clr_busy_q && (!s0_v || s0_adv);
	assign accept    = req.valid && req.ready;

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == SET_W'(SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	stlb_index #(
		.SETS  (SETS),
		.SET_W (SET_W)
	) u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.req_in   (req_n),
		.advance  (s0_adv),
		.valid_s0 (s0_v),
		.req_s0   (req_s0),
		.set_s0   (set_s0)
	);

	assign we    = clr_busy_q || (s1_adv && res.wr);
	assign waddr = clr_busy_q ? clr_idx_q : set_s1;
	assign wdata = clr_busy_q ? '0 : row_new;

	stlb_ram #(
		.WIDTH  (ROW_W),
		.DEPTH  (SETS),
		.ADDR_W (SET_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (s0_adv),
		.raddr (set_s0),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (s0_adv) begin
				s1_v_q <= 1'b1;
				fwd_s1 <= s1_adv && res.wr && (set_s1 == set_s0);
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
				fwd_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s0_adv) begin
			req_s1 <= req_s0;
			set_s1 <= set_s0;
		end
		if (s1_adv && res.wr) begin
			fwd_row_q <= row_new;
		end
	end

	assign rd_row = rdata;
	assign row_s1 = fwd_s1 ? fwd_row_q : rd_row;

	stlb_match #(
		.WAYS (WAYS)
	) u_match (
		.req     (req_s1),
		.row     (row_s1),
		.row_new (row_new),
		.res     (res)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q <= res.status;
			frame_q  <= res.frame;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.status    = status_q;
	assign rsp.frame_out = frame_q;

	`ASSERT_CLK(a_idle_in_clear, clr_busy_q |-> !(s0_v || s1_v_q || out_v_q), "work in clear")
	`ASSERT_ALWAYS(a_fwd_needs_item, fwd_s1 |-> s1_v_q, "forward flag without item")
	`ASSERT_CLK(a_status_code, out_v_q |-> (status_q <= ST_FULL), "bad status code")
	`ASSERT_CLK(a_frame_on_hit, (out_v_q && frame_q != '0) |-> (status_q == ST_OK), "frame on miss")

endmodule

`default_nettype wire
